FILE: design/spv_pkg.sv
// ----------------------------------------------------------------------------
// spv_pkg
// Shared types, constants and tables for the polyphonic sample player.
// ----------------------------------------------------------------------------
package spv_pkg;

    localparam int VOICE_COUNT  = 16;
    localparam int SAMPLE_DEPTH = 65536;

    localparam int VI_W = (VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1;
    localparam int VC_W = $clog2(VOICE_COUNT + 1);
    localparam int SA_W = $clog2(SAMPLE_DEPTH);

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    localparam logic [23:0] ENV_ONE   = 24'h800000;
    localparam logic [23:0] STEP_MAX  = 24'hFFFFFF;
    localparam logic [15:0] START_CAP = 16'd64880;
    localparam logic [16:0] MIN_GAP   = 17'd655;
    localparam logic [16:0] FRAC_ONE  = 17'd65536;

    typedef enum logic [2:0] {
        FN_TICK     = 3'd0,
        FN_NOTE_ON  = 3'd1,
        FN_NOTE_OFF = 3'd2,
        FN_ALL_OFF  = 3'd3,
        FN_WRITE    = 3'd4
    } t_func;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LENGTH    = 3'd0,
        CFG_START     = 3'd1,
        CFG_END       = 3'd2,
        CFG_MODE      = 3'd3,
        CFG_TRANSPOSE = 3'd4,
        CFG_ATTACK    = 3'd5,
        CFG_RELEASE   = 3'd6,
        CFG_GAIN      = 3'd7
    } t_cfg_idx;

    typedef enum logic [4:0] {
        S_IDLE,
        S_REG_ST,
        S_REG_EN,
        S_PITCH0,
        S_PITCH1,
        S_PITCH2,
        S_PITCH3,
        S_PITCH4,
        S_PITCH5,
        S_PITCH6,
        S_ON_WR,
        S_OFF_RD,
        S_OFF_CHK,
        S_TK_RD,
        S_TK_ENV,
        S_TK_S0,
        S_TK_S1,
        S_TK_M1,
        S_TK_M2,
        S_TK_M3,
        S_TK_M4,
        S_TK_DIV,
        S_TK_WB,
        S_TK_OUT
    } t_state;

    typedef struct packed {
        logic               releasing;
        logic [6:0]         note;
        logic [15:0]        velocity;
        logic signed [33:0] position;
        logic [23:0]        step;
        logic [23:0]        envelope;
    } t_voice;

    // one octave of semitone ratios, Q16
    function automatic logic [17:0] semitone_q16(input logic [3:0] idx);
        logic [17:0] v;
        case (idx)
            4'd0:    v = 18'd65536;
            4'd1:    v = 18'd69433;
            4'd2:    v = 18'd73562;
            4'd3:    v = 18'd77936;
            4'd4:    v = 18'd82570;
            4'd5:    v = 18'd87480;
            4'd6:    v = 18'd92682;
            4'd7:    v = 18'd98193;
            4'd8:    v = 18'd104032;
            4'd9:    v = 18'd110218;
            4'd10:   v = 18'd116772;
            4'd11:   v = 18'd123715;
            default: v = 18'd131072;
        endcase
        return v;
    endfunction

endpackage

FILE: design/spv_in_if.sv
// ----------------------------------------------------------------------------
// spv_in_if
// Command channel: tick, note on/off, all off and sample write beats.
// ----------------------------------------------------------------------------
interface spv_in_if;
    logic               valid;
    logic               ready;
    logic [2:0]         func;
    logic [6:0]         note;
    logic [15:0]        velocity;
    logic [15:0]        sample_address;
    logic signed [15:0] sample_left;
    logic signed [15:0] sample_right;

    modport source (
        output valid, func, note, velocity, sample_address, sample_left, sample_right,
        input  ready
    );
    modport sink (
        input  valid, func, note, velocity, sample_address, sample_left, sample_right,
        output ready
    );
endinterface

FILE: design/spv_out_if.sv
// ----------------------------------------------------------------------------
// spv_out_if
// Result channel: one mixed stereo sample per tick.
// ----------------------------------------------------------------------------
interface spv_out_if;
    logic               valid;
    logic               ready;
    logic signed [23:0] left_out;
    logic signed [23:0] right_out;

    modport source (output valid, left_out, right_out, input ready);
    modport sink   (input valid, left_out, right_out, output ready);
endinterface

FILE: design/polyphonic_sample_playback_voices_core.sv
// ----------------------------------------------------------------------------
// polyphonic_sample_playback_voices_core
// Sampler with per-voice linear envelope and linearly interpolated reads.
// Voice state and sample data live in two RAMs, processed voice by voice.
// ----------------------------------------------------------------------------
// channel   dir   beat contents
// i_in      in    func, note, velocity, sample_address, sample_left/right
// o_out     out   left_out, right_out (one beat per tick)
// i_cfg_*   in    write enable, register index, data
//
// Sample write: taken in idle. Note off / all off: a playing voice is marked
// releasing if its note matches or for all off. Note on: region and pitch
// multiplies in turn, then the voice write. Tick: per playing voice, envelope,
// sample reads, multiplies and write-back, plus a bit-serial remainder for a
// voice whose loop wrap spans more than one loop length. Reset clears voice
// activity at once; the sample store is not cleared. A finished tick holds in
// the output register until taken; other beats are accepted meanwhile.
// ----------------------------------------------------------------------------
module polyphonic_sample_playback_voices_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    spv_in_if.sink                        i_in,
    spv_out_if.source                     o_out,
    input  logic                          i_cfg_wr_en,
    input  logic [spv_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [spv_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    localparam int VI_W = spv_pkg::VI_W;
    localparam int VC_W = spv_pkg::VC_W;
    localparam int SA_W = spv_pkg::SA_W;
    localparam int VW   = $bits(spv_pkg::t_voice);
    localparam logic [24:0] DEPTH_W = 25'(spv_pkg::SAMPLE_DEPTH);

    // configuration
    logic [16:0]        r_len;
    logic [15:0]        r_sf;
    logic [16:0]        r_ef;
    logic [1:0]         r_mode;
    logic signed [14:0] r_trans;
    logic [23:0]        r_att;
    logic [23:0]        r_rel;
    logic [15:0]        r_gain;

    spv_pkg::t_state r_state, n_state;

    logic [VOICE_COUNT_M1:0] r_active;
    localparam int VOICE_COUNT_M1 = spv_pkg::VOICE_COUNT - 1;

    logic [2:0]  r_func;
    logic [6:0]  r_note;
    logic [15:0] r_vel;
    logic [VC_W-1:0] r_vcnt;
    logic [VI_W-1:0] w_idx;

    logic [15:0] r_st;
    logic [16:0] r_en;

    logic [15:0] r_u;
    logic [5:0]  r_q;
    logic [10:0] r_rem_c;
    logic [3:0]  r_semi;
    logic [6:0]  r_frc;
    logic [19:0] r_x;
    logic [17:0] r_base;
    logic [17:0] r_m;
    logic [23:0] r_step;

    spv_pkg::t_voice r_voice;
    logic [15:0]        r_i1;
    logic [15:0]        r_fr;
    logic [31:0]        r_w0;
    logic signed [33:0] r_dl, r_dr;
    logic signed [33:0] r_al, r_ar;
    logic signed [46:0] r_phl, r_pll, r_phr, r_plr;
    logic signed [49:0] r_gl, r_gr;
    logic signed [33:0] r_pos_n;
    logic signed [19:0] r_dh;
    logic signed [35:0] r_accl, r_accr;
    logic [18:0]        r_div_a;
    logic               r_div_neg;
    logic [16:0]        r_rem;
    logic [4:0]         r_div_cnt;

    logic               r_ov;
    logic signed [23:0] r_left, r_right;

    // ---------------------------------------------------------------- derived
    logic        w_in_acc;
    logic [16:0] w_len;
    logic        w_short;
    logic [15:0] w_lm1;
    logic [23:0] w_att, w_rel;
    logic [16:0] w_n;

    assign w_in_acc = i_in.valid && i_in.ready;
    assign i_in.ready = (r_state == spv_pkg::S_IDLE);
    assign w_len = ({8'd0, r_len} < DEPTH_W) ? r_len : 17'(spv_pkg::SAMPLE_DEPTH);
    assign w_short = (w_len < 17'd2);
    assign w_lm1 = 16'(w_len - 17'd1);
    assign w_att = (r_att == 24'd0) ? 24'd1 : ((r_att > spv_pkg::ENV_ONE) ? spv_pkg::ENV_ONE : r_att);
    assign w_rel = (r_rel == 24'd0) ? 24'd1 : ((r_rel > spv_pkg::ENV_ONE) ? spv_pkg::ENV_ONE : r_rel);
    assign w_n = r_en - {1'b0, r_st};
    assign w_idx = r_vcnt[VI_W-1:0];

    // ------------------------------------------------------------------ RAMs
    logic                 v_we;
    logic [VI_W-1:0]      v_waddr;
    spv_pkg::t_voice      v_wdata;
    logic [VW-1:0]        v_rdata;
    spv_pkg::t_voice      w_vd;

    logic                 s_we;
    logic [SA_W-1:0]      s_raddr;
    logic [31:0]          s_rdata;

    assign w_vd = spv_pkg::t_voice'(v_rdata);

    spv_ram #(.WIDTH(VW), .DEPTH(spv_pkg::VOICE_COUNT)) u_voice_ram (
        .i_clk     (i_clk),
        .i_wr_en   (v_we),
        .i_wr_addr (v_waddr),
        .i_wr_data (v_wdata),
        .i_rd_addr (w_idx),
        .o_rd_data (v_rdata)
    );

    assign s_we = w_in_acc && (i_in.func == spv_pkg::FN_WRITE)
                  && ({9'd0, i_in.sample_address} < DEPTH_W);

    spv_ram #(.WIDTH(32), .DEPTH(spv_pkg::SAMPLE_DEPTH)) u_sample_ram (
        .i_clk     (i_clk),
        .i_wr_en   (s_we),
        .i_wr_addr (SA_W'(i_in.sample_address)),
        .i_wr_data ({i_in.sample_right, i_in.sample_left}),
        .i_rd_addr (s_raddr),
        .o_rd_data (s_rdata)
    );

    // ---------------------------------------------------------------- region
    logic [15:0] w_sfc;
    logic [31:0] w_st_prod;
    logic [15:0] w_lm2;
    logic [16:0] w_lo, w_efc, w_st2;
    logic [33:0] w_en_prod;
    logic [17:0] w_en_raw;

    assign w_sfc = (r_sf < spv_pkg::START_CAP) ? r_sf : spv_pkg::START_CAP;
    assign w_st_prod = 32'(w_sfc) * 32'(w_lm1);
    assign w_lm2 = w_lm1 - 16'd1;
    assign w_lo = {1'b0, r_sf} + spv_pkg::MIN_GAP;
    assign w_efc = (r_ef < w_lo) ? w_lo
                 : ((r_ef > spv_pkg::FRAC_ONE) ? spv_pkg::FRAC_ONE : r_ef);
    assign w_en_prod = 34'(w_efc) * 34'(w_lm1) + 34'd65535;
    assign w_en_raw = w_en_prod[33:16];
    assign w_st2 = {1'b0, r_st} + 17'd2;

    // ----------------------------------------------------------------- pitch
    logic signed [17:0] w_u;
    logic [31:0]        w_q_prod;
    logic [15:0]        w_q1200;
    logic [3:0]         w_semi;
    logic [10:0]        w_semi100;
    logic [17:0]        w_tnext;
    logic [41:0]        w_y_prod;
    logic signed [6:0]  w_oct;
    logic [39:0]        w_shl;
    logic [17:0]        w_shr;
    logic [23:0]        w_step_new;

    assign w_u = $signed({1'b0, 17'(r_note) * 17'd100}) + 18'sd13200 + 18'(r_trans);
    assign w_q_prod = 32'(r_u) * 32'd55925;
    assign w_q1200 = 16'(r_q) * 16'd1200;

    always_comb begin
        w_semi = 4'd0;
        for (int k = 1; k < 12; k++) begin
            if (r_rem_c >= 11'(k * 100)) begin
                w_semi = w_semi + 4'd1;
            end
        end
    end

    assign w_semi100 = 11'(w_semi) * 11'd100;
    assign w_tnext = spv_pkg::semitone_q16(r_semi + 4'd1);
    assign w_y_prod = 42'(r_x) * 42'd2684355;
    assign w_oct = $signed({1'b0, r_q}) - 7'sd11;
    assign w_shl = 40'(r_m) << w_oct[4:0];
    assign w_shr = r_m >> 5'(-w_oct);
    assign w_step_new = (w_oct >= 0) ? ((|w_shl[39:24]) ? spv_pkg::STEP_MAX : w_shl[23:0])
                                     : 24'(w_shr);

    // first idle voice, voice 0 when all play
    logic [VI_W-1:0] w_vsel;
    always_comb begin
        w_vsel = '0;
        for (int i = spv_pkg::VOICE_COUNT - 1; i >= 0; i--) begin
            if (!r_active[i]) begin
                w_vsel = VI_W'(i);
            end
        end
    end

    // -------------------------------------------------------------- envelope
    logic [23:0] w_env_dec, w_env_inc, w_env_new;
    logic [24:0] w_env_sum;
    logic        w_freed;
    logic [31:0] w_top, w_p;
    logic [15:0] w_i0, w_i1;

    assign w_env_dec = (w_vd.envelope > w_rel) ? (w_vd.envelope - w_rel) : 24'd0;
    assign w_env_sum = {1'b0, w_vd.envelope} + {1'b0, w_att};
    assign w_env_inc = (w_env_sum > {1'b0, spv_pkg::ENV_ONE}) ? spv_pkg::ENV_ONE
                                                              : w_env_sum[23:0];
    assign w_env_new = w_vd.releasing ? w_env_dec : w_env_inc;
    assign w_freed = w_vd.releasing && (w_env_dec == 24'd0);

    assign w_top = {w_lm1, 16'd0};
    assign w_p = (w_vd.position < 0) ? 32'd0
               : ((w_vd.position > $signed({2'b00, w_top})) ? w_top : w_vd.position[31:0]);
    assign w_i0 = w_p[31:16];
    assign w_i1 = (w_i0 == w_lm1) ? w_lm1 : (w_i0 + 16'd1);

    assign s_raddr = (r_state == spv_pkg::S_TK_ENV) ? SA_W'(w_i0) : SA_W'(r_i1);

    // ---------------------------------------------------------- interpolation
    logic signed [16:0] w_frs, w_diff_l, w_diff_r, w_vels;
    logic signed [33:0] w_prod_l, w_prod_r;
    logic signed [17:0] w_int_l, w_int_r;
    logic signed [12:0] w_envh, w_envl;
    logic signed [58:0] w_t_l, w_t_r;
    logic signed [32:0] w_tt_l, w_tt_r;
    logic signed [16:0] w_gain;

    assign w_frs = $signed({1'b0, r_fr});
    assign w_diff_l = 17'($signed(s_rdata[15:0])) - 17'($signed(r_w0[15:0]));
    assign w_diff_r = 17'($signed(s_rdata[31:16])) - 17'($signed(r_w0[31:16]));
    assign w_prod_l = w_diff_l * w_frs;
    assign w_prod_r = w_diff_r * w_frs;
    assign w_int_l = 18'($signed(r_w0[15:0])) + 18'(r_dl >>> 16);
    assign w_int_r = 18'($signed(r_w0[31:16])) + 18'(r_dr >>> 16);
    assign w_vels = $signed({1'b0, r_voice.velocity});
    assign w_envh = $signed({1'b0, r_voice.envelope[23:12]});
    assign w_envl = $signed({1'b0, r_voice.envelope[11:0]});
    assign w_t_l = ((59'(r_phl) <<< 12) + 59'(r_pll)) >>> 23;
    assign w_t_r = ((59'(r_phr) <<< 12) + 59'(r_plr)) >>> 23;
    assign w_tt_l = 33'(w_t_l);
    assign w_tt_r = 33'(w_t_r);
    assign w_gain = $signed({1'b0, r_gain});

    // -------------------------------------------------------------- position
    logic signed [34:0] w_stp, w_psum;
    logic signed [33:0] w_psat;
    logic signed [35:0] w_d;
    logic signed [20:0] w_dh, w_n21;
    logic [16:0]        w_rh_fast;
    logic               w_fast;
    logic signed [33:0] w_s_pos, w_e_pos, w_wrap_pos, w_div_pos;
    logic               w_oob;
    logic [17:0]        w_dt;
    logic               w_dge;
    logic [16:0]        w_rh_div;

    assign w_stp = $signed({11'd0, r_voice.step});
    assign w_psum = r_mode[0] ? (35'(r_voice.position) - w_stp)
                              : (35'(r_voice.position) + w_stp);
    assign w_psat = (w_psum[34] != w_psum[33])
                  ? (w_psum[34] ? {1'b1, 33'd0} : {1'b0, {33{1'b1}}})
                  : w_psum[33:0];
    assign w_d = 36'(r_pos_n) - $signed({4'd0, r_st, 16'd0});

    assign w_dh = 21'(r_dh);
    assign w_n21 = $signed({4'd0, w_n});
    always_comb begin
        w_fast = 1'b1;
        w_rh_fast = 17'(w_dh);
        if (w_dh >= 0 && w_dh < w_n21) begin
            w_rh_fast = 17'(w_dh);
        end else if (w_dh < 0 && w_dh >= -w_n21) begin
            w_rh_fast = 17'(w_dh + w_n21);
        end else if (w_dh >= w_n21 && w_dh < (w_n21 <<< 1)) begin
            w_rh_fast = 17'(w_dh - w_n21);
        end else begin
            w_fast = 1'b0;
        end
    end

    assign w_s_pos = $signed({2'd0, r_st, 16'd0});
    assign w_e_pos = $signed({1'b0, r_en, 16'd0});
    assign w_oob = (r_pos_n >= w_e_pos) || (r_pos_n < w_s_pos);
    assign w_wrap_pos = $signed({2'd0, 16'(r_st + 16'(w_rh_fast)), r_pos_n[15:0]});

    assign w_dt = {r_rem, r_div_a[18]};
    assign w_dge = (w_dt >= {1'b0, w_n});
    assign w_rh_div = r_div_neg ? (w_n - 17'd1 - r_rem) : r_rem;
    assign w_div_pos = $signed({2'd0, 16'(r_st + 16'(w_rh_div)), r_pos_n[15:0]});

    // ----------------------------------------------------------- output sat
    logic signed [23:0] w_sat_l, w_sat_r;
    assign w_sat_l = (r_accl > 36'sd8388607) ? 24'sh7FFFFF
                   : ((r_accl < -36'sd8388608) ? 24'sh800000 : 24'(r_accl));
    assign w_sat_r = (r_accr > 36'sd8388607) ? 24'sh7FFFFF
                   : ((r_accr < -36'sd8388608) ? 24'sh800000 : 24'(r_accr));

    // ------------------------------------------------------ control, voice wr
    spv_pkg::t_voice w_new_voice;
    always_comb begin
        w_new_voice.releasing = 1'b0;
        w_new_voice.note      = r_note;
        w_new_voice.velocity  = r_vel;
        w_new_voice.position  = r_mode[0] ? $signed({2'd0, 16'(r_en - 17'd1), 16'd0})
                                          : $signed({2'd0, r_st, 16'd0});
        w_new_voice.step      = r_step;
        w_new_voice.envelope  = 24'd0;
    end

    always_comb begin
        n_state = r_state;
        v_we    = 1'b0;
        v_waddr = w_idx;
        v_wdata = r_voice;
        case (r_state)
            spv_pkg::S_IDLE: begin
                if (w_in_acc) begin
                    case (i_in.func)
                        spv_pkg::FN_TICK:     n_state = w_short ? spv_pkg::S_TK_OUT
                                                                : spv_pkg::S_REG_ST;
                        spv_pkg::FN_NOTE_ON:  n_state = w_short ? spv_pkg::S_IDLE
                                                                : spv_pkg::S_REG_ST;
                        spv_pkg::FN_NOTE_OFF,
                        spv_pkg::FN_ALL_OFF:  n_state = spv_pkg::S_OFF_RD;
                        default:              n_state = spv_pkg::S_IDLE;
                    endcase
                end
            end
            spv_pkg::S_REG_ST: n_state = spv_pkg::S_REG_EN;
            spv_pkg::S_REG_EN: begin
                n_state = (r_func == spv_pkg::FN_TICK) ? spv_pkg::S_TK_RD : spv_pkg::S_PITCH0;
            end
            spv_pkg::S_PITCH0: n_state = spv_pkg::S_PITCH1;
            spv_pkg::S_PITCH1: n_state = spv_pkg::S_PITCH2;
            spv_pkg::S_PITCH2: n_state = spv_pkg::S_PITCH3;
            spv_pkg::S_PITCH3: n_state = spv_pkg::S_PITCH4;
            spv_pkg::S_PITCH4: n_state = spv_pkg::S_PITCH5;
            spv_pkg::S_PITCH5: n_state = spv_pkg::S_PITCH6;
            spv_pkg::S_PITCH6: n_state = spv_pkg::S_ON_WR;
            spv_pkg::S_ON_WR: begin
                v_we    = 1'b1;
                v_waddr = w_vsel;
                v_wdata = w_new_voice;
                n_state = spv_pkg::S_IDLE;
            end
            spv_pkg::S_OFF_RD: begin
                if (r_vcnt == VC_W'(spv_pkg::VOICE_COUNT)) begin
                    n_state = spv_pkg::S_IDLE;
                end else if (r_active[w_idx]) begin
                    n_state = spv_pkg::S_OFF_CHK;
                end
            end
            spv_pkg::S_OFF_CHK: begin
                v_wdata = w_vd;
                v_wdata.releasing = 1'b1;
                v_we = (r_func == spv_pkg::FN_ALL_OFF) || (w_vd.note == r_note);
                n_state = spv_pkg::S_OFF_RD;
            end
            spv_pkg::S_TK_RD: begin
                if (r_vcnt == VC_W'(spv_pkg::VOICE_COUNT)) begin
                    n_state = spv_pkg::S_TK_OUT;
                end else if (r_active[w_idx]) begin
                    n_state = spv_pkg::S_TK_ENV;
                end
            end
            spv_pkg::S_TK_ENV: n_state = w_freed ? spv_pkg::S_TK_RD : spv_pkg::S_TK_S0;
            spv_pkg::S_TK_S0:  n_state = spv_pkg::S_TK_S1;
            spv_pkg::S_TK_S1:  n_state = spv_pkg::S_TK_M1;
            spv_pkg::S_TK_M1:  n_state = spv_pkg::S_TK_M2;
            spv_pkg::S_TK_M2:  n_state = spv_pkg::S_TK_M3;
            spv_pkg::S_TK_M3:  n_state = spv_pkg::S_TK_M4;
            spv_pkg::S_TK_M4: begin
                if (r_mode[1] && !w_fast) begin
                    n_state = spv_pkg::S_TK_DIV;
                end else begin
                    v_we = 1'b1;
                    if (r_mode[1]) begin
                        v_wdata.position = w_wrap_pos;
                    end else begin
                        v_wdata.position  = r_pos_n;
                        v_wdata.releasing = r_voice.releasing || w_oob;
                    end
                    n_state = spv_pkg::S_TK_RD;
                end
            end
            spv_pkg::S_TK_DIV: begin
                if (r_div_cnt == 5'd1) begin
                    n_state = spv_pkg::S_TK_WB;
                end
            end
            spv_pkg::S_TK_WB: begin
                v_we = 1'b1;
                v_wdata.position = w_div_pos;
                n_state = spv_pkg::S_TK_RD;
            end
            spv_pkg::S_TK_OUT: begin
                if (!r_ov || o_out.ready) begin
                    n_state = spv_pkg::S_IDLE;
                end
            end
            default: n_state = spv_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= spv_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // ---------------------------------------------------------- config regs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len   <= 17'd0;
            r_sf    <= 16'd0;
            r_ef    <= 17'd65536;
            r_mode  <= 2'd0;
            r_trans <= -15'sd6000;
            r_att   <= spv_pkg::ENV_ONE;
            r_rel   <= spv_pkg::ENV_ONE;
            r_gain  <= 16'd4096;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                spv_pkg::CFG_LENGTH:    r_len   <= i_cfg_data[16:0];
                spv_pkg::CFG_START:     r_sf    <= i_cfg_data[15:0];
                spv_pkg::CFG_END:       r_ef    <= i_cfg_data[16:0];
                spv_pkg::CFG_MODE:      r_mode  <= i_cfg_data[1:0];
                spv_pkg::CFG_TRANSPOSE: r_trans <= $signed(i_cfg_data[14:0]);
                spv_pkg::CFG_ATTACK:    r_att   <= i_cfg_data[23:0];
                spv_pkg::CFG_RELEASE:   r_rel   <= i_cfg_data[23:0];
                spv_pkg::CFG_GAIN:      r_gain  <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // ----------------------------------------------------- activity, output
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= '0;
            r_ov     <= 1'b0;
        end else begin
            if (r_state == spv_pkg::S_ON_WR) begin
                r_active[w_vsel] <= 1'b1;
            end else if (r_state == spv_pkg::S_TK_ENV && w_freed) begin
                r_active[w_idx] <= 1'b0;
            end
            if (r_state == spv_pkg::S_TK_OUT && (!r_ov || o_out.ready)) begin
                r_ov <= 1'b1;
            end else if (o_out.ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == spv_pkg::S_TK_OUT && (!r_ov || o_out.ready)) begin
            r_left  <= w_sat_l;
            r_right <= w_sat_r;
        end
    end

    assign o_out.valid     = r_ov;
    assign o_out.left_out  = r_left;
    assign o_out.right_out = r_right;

    // -------------------------------------------------------------- datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            spv_pkg::S_IDLE: begin
                if (w_in_acc) begin
                    r_func <= i_in.func;
                    r_note <= i_in.note;
                    r_vel  <= (i_in.velocity > 16'd32768) ? 16'd32768 : i_in.velocity;
                    r_vcnt <= '0;
                    r_accl <= '0;
                    r_accr <= '0;
                end
            end
            spv_pkg::S_REG_ST: begin
                r_st <= (w_st_prod[31:16] > w_lm2) ? w_lm2 : w_st_prod[31:16];
            end
            spv_pkg::S_REG_EN: begin
                if ({1'b0, w_en_raw} < {2'b0, w_st2}) begin
                    r_en <= w_st2;
                end else if (w_en_raw > {1'b0, w_len}) begin
                    r_en <= w_len;
                end else begin
                    r_en <= w_en_raw[16:0];
                end
            end
            spv_pkg::S_PITCH0: r_u <= w_u[15:0];
            spv_pkg::S_PITCH1: r_q <= w_q_prod[31:26];
            spv_pkg::S_PITCH2: r_rem_c <= 11'(r_u - w_q1200);
            spv_pkg::S_PITCH3: begin
                r_semi <= w_semi;
                r_frc  <= 7'(r_rem_c - w_semi100);
            end
            spv_pkg::S_PITCH4: begin
                r_base <= spv_pkg::semitone_q16(r_semi);
                r_x    <= 20'(13'(w_tnext - spv_pkg::semitone_q16(r_semi))) * 20'(r_frc);
            end
            spv_pkg::S_PITCH5: r_m <= r_base + 18'(w_y_prod[41:28]);
            spv_pkg::S_PITCH6: r_step <= w_step_new;
            spv_pkg::S_OFF_RD: begin
                if (r_vcnt != VC_W'(spv_pkg::VOICE_COUNT) && !r_active[w_idx]) begin
                    r_vcnt <= r_vcnt + 1'b1;
                end
            end
            spv_pkg::S_OFF_CHK: r_vcnt <= r_vcnt + 1'b1;
            spv_pkg::S_TK_RD: begin
                if (r_vcnt != VC_W'(spv_pkg::VOICE_COUNT) && !r_active[w_idx]) begin
                    r_vcnt <= r_vcnt + 1'b1;
                end
            end
            spv_pkg::S_TK_ENV: begin
                r_voice          <= w_vd;
                r_voice.envelope <= w_env_new;
                r_i1             <= w_i1;
                r_fr             <= w_p[15:0];
                if (w_freed) begin
                    r_vcnt <= r_vcnt + 1'b1;
                end
            end
            spv_pkg::S_TK_S0: r_w0 <= s_rdata;
            spv_pkg::S_TK_S1: begin
                r_dl <= w_prod_l;
                r_dr <= w_prod_r;
            end
            spv_pkg::S_TK_M1: begin
                r_al    <= 34'(w_int_l * w_vels);
                r_ar    <= 34'(w_int_r * w_vels);
                r_pos_n <= w_psat;
            end
            spv_pkg::S_TK_M2: begin
                r_phl <= r_al * w_envh;
                r_pll <= r_al * w_envl;
                r_phr <= r_ar * w_envh;
                r_plr <= r_ar * w_envl;
                r_dh  <= w_d[35:16];
            end
            spv_pkg::S_TK_M3: begin
                r_gl <= w_tt_l * w_gain;
                r_gr <= w_tt_r * w_gain;
            end
            spv_pkg::S_TK_M4: begin
                r_accl    <= r_accl + 36'(r_gl >>> 19);
                r_accr    <= r_accr + 36'(r_gr >>> 19);
                // wrap further than one loop length: bit-serial remainder
                r_div_neg <= r_dh[19];
                r_div_a   <= r_dh[19] ? ~r_dh[18:0] : r_dh[18:0];
                r_rem     <= '0;
                r_div_cnt <= 5'd19;
                if (!(r_mode[1] && !w_fast)) begin
                    r_vcnt <= r_vcnt + 1'b1;
                end
            end
            spv_pkg::S_TK_DIV: begin
                r_rem     <= w_dge ? 17'(w_dt - {1'b0, w_n}) : w_dt[16:0];
                r_div_a   <= {r_div_a[17:0], 1'b0};
                r_div_cnt <= r_div_cnt - 5'd1;
            end
            spv_pkg::S_TK_WB: r_vcnt <= r_vcnt + 1'b1;
            default: ;
        endcase
    end

endmodule

FILE: design/spv_ram.sv
// ----------------------------------------------------------------------------
// spv_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module spv_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule
